// File: rtl/dsgcr_pkg.sv
// shared types, constants and gcr helpers for the disk sector gcr encoder
`timescale 1ns / 1ps
package dsgcr_pkg;

  localparam int SECTOR_BYTES = 256;
  localparam int POS_W        = $clog2(SECTOR_BYTES);
  localparam int CMD_DEPTH    = 4;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] HEADER_MARK = 8'h08;
  localparam logic [7:0] DATA_MARK   = 8'h07;
  localparam logic [7:0] HEADER_PAD  = 8'h0F;
  localparam logic [7:0] GAP_BYTE    = 8'h55;
  localparam logic [2:0] SYNC_LAST   = 3'd4;
  localparam logic [2:0] GROUP_LAST  = 3'd4;
  localparam logic [5:0] HGAP_MAX    = 6'd32;
  localparam logic [5:0] TGAP_MAX    = 6'd59;

  localparam logic [5:0] RST_TRACK = 6'd18;
  localparam logic [5:0] RST_GAP   = 6'd9;

  typedef enum logic [2:0] {
    REG_TRACK = 3'd0,
    REG_ID1   = 3'd1,
    REG_ID2   = 3'd2,
    REG_HGAP  = 3'd3,
    REG_TGAP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [4:0] sector_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gcr_byte;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [5:0] track_number;
    logic [7:0] disk_id_first;
    logic [7:0] disk_id_second;
    logic [5:0] header_gap_count;
    logic [5:0] tail_gap_count;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_GRP  = 2'd1,
    CMD_TAIL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] bytes;
  } cmd_t;

  function automatic logic [4:0] nib5(input logic [3:0] n);
    logic [4:0] c;
    case (n)
      4'h0: c = 5'h0a;
      4'h1: c = 5'h0b;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h0e;
      4'h5: c = 5'h0f;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h09;
      4'h9: c = 5'h19;
      4'ha: c = 5'h1a;
      4'hb: c = 5'h1b;
      4'hc: c = 5'h0d;
      4'hd: c = 5'h1d;
      4'he: c = 5'h1e;
      default: c = 5'h15;
    endcase
    return c;
  endfunction

  // four bytes, msb first, become forty code bits
  function automatic logic [39:0] gcr_encode(input logic [31:0] b);
    logic [39:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[5*i +: 5] = nib5(b[4*i +: 4]);
    end
    return r;
  endfunction

endpackage

// File: rtl/dsgcr_front.sv
// front end: tracks sector position, builds group and framing requests
`timescale 1ns / 1ps
module dsgcr_front
  import dsgcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_take,
  input  in_item_t in_item,
  output logic     cmd_wr,
  output cmd_t     cmd_data
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [23:0]      hold_r, hold_nxt;
  logic [7:0]       csum_r, csum_nxt;
  logic [7:0]       d;
  logic [7:0]       sec8;
  logic [7:0]       trk8;
  logic [7:0]       csum_upd;

  assign d        = in_item.data_byte;
  assign sec8     = {3'b000, in_item.sector_index};
  assign trk8     = {2'b00, cfg.track_number};
  assign csum_upd = csum_r ^ d;

  always_comb begin
    pos_nxt  = pos_r;
    hold_nxt = hold_r;
    csum_nxt = csum_r;
    cmd_wr   = 1'b0;
    cmd_data = '{kind: CMD_GRP, bytes: {hold_r, d}};
    if (in_take) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == '0) begin
        cmd_wr   = 1'b1;
        cmd_data = '{kind: CMD_HDR,
                     bytes: {HEADER_MARK,
                             sec8 ^ trk8 ^ cfg.disk_id_second ^ cfg.disk_id_first,
                             sec8, trk8}};
        csum_nxt = d;
        hold_nxt = {8'h00, DATA_MARK, d};
      end else if (pos_r == POS_W'(SECTOR_BYTES - 1)) begin
        cmd_wr   = 1'b1;
        cmd_data = '{kind: CMD_TAIL, bytes: {d, csum_upd, 16'h0000}};
        csum_nxt = csum_upd;
        hold_nxt = '0;
      end else begin
        csum_nxt = csum_upd;
        // a group closes at positions 2, 6, 10, ...
        if (pos_r[1:0] == 2'b10) begin
          cmd_wr   = 1'b1;
          hold_nxt = '0;
        end else begin
          hold_nxt = {hold_r[15:0], d};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hold_r <= '0;
      csum_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
      csum_r <= csum_nxt;
    end
  end

endmodule

// File: rtl/dsgcr_cmd_fifo.sv
// short request queue between front and back
`timescale 1ns / 1ps
module dsgcr_cmd_fifo
  import dsgcr_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  cmd_t                       wr_data,
  input  logic                       rd,
  output cmd_t                       rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [LW-1:0] cnt_r;

  assign full    = (cnt_r == LW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/dsgcr_back.sv
// back end: expands each request into output bytes, one per cycle unless pop is held off
`timescale 1ns / 1ps
module dsgcr_back
  import dsgcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_avail,
  input  cmd_t      cmd_data,
  output logic      cmd_rd,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYNC_A,
    ST_GRP_A,
    ST_GRP_B,
    ST_GAP,
    ST_SYNC_B
  } state_t;

  state_t      state_r, state_nxt;
  cmd_kind_t   kind_r, kind_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [39:0] shift_r, shift_nxt;
  logic        oval_r, oval_nxt;
  out_item_t   oitem_r, oitem_nxt;
  logic        adv;
  logic [5:0]  hgap;
  logic [5:0]  tgap;
  logic [5:0]  gap_len;

  assign hgap    = (cfg.header_gap_count > HGAP_MAX) ? HGAP_MAX : cfg.header_gap_count;
  assign tgap    = (cfg.tail_gap_count > TGAP_MAX) ? TGAP_MAX : cfg.tail_gap_count;
  assign gap_len = (kind_r == CMD_HDR) ? hgap : tgap;

  assign adv       = !oval_r || out_pop;
  assign cmd_rd    = (state_r == ST_IDLE) && cmd_avail;
  assign out_empty = !oval_r;
  assign out_item  = oitem_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    oval_nxt  = oval_r && !out_pop;
    oitem_nxt = oitem_r;
    if (state_r == ST_IDLE) begin
      if (cmd_avail) begin
        kind_nxt  = cmd_data.kind;
        cnt_nxt   = '0;
        shift_nxt = gcr_encode(cmd_data.bytes);
        state_nxt = (cmd_data.kind == CMD_HDR) ? ST_SYNC_A : ST_GRP_A;
      end
    end else if (adv) begin
      oval_nxt           = 1'b1;
      oitem_nxt.run_last = 1'b0;
      cnt_nxt            = cnt_r + 1'b1;
      unique case (state_r)
        ST_SYNC_A: begin
          oitem_nxt.gcr_byte = SYNC_BYTE;
          if (cnt_r[2:0] == SYNC_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_GRP_A;
          end
        end
        ST_GRP_A, ST_GRP_B: begin
          oitem_nxt.gcr_byte = shift_r[39:32];
          shift_nxt          = {shift_r[31:0], 8'h00};
          if (cnt_r[2:0] == GROUP_LAST) begin
            cnt_nxt = '0;
            if (state_r == ST_GRP_B) begin
              state_nxt = (hgap == '0) ? ST_SYNC_B : ST_GAP;
            end else if (kind_r == CMD_HDR) begin
              shift_nxt = gcr_encode({cfg.disk_id_second, cfg.disk_id_first,
                                      HEADER_PAD, HEADER_PAD});
              state_nxt = ST_GRP_B;
            end else if (kind_r == CMD_TAIL && tgap != '0) begin
              state_nxt = ST_GAP;
            end else begin
              oitem_nxt.run_last = 1'b1;
              state_nxt          = ST_IDLE;
            end
          end
        end
        ST_GAP: begin
          oitem_nxt.gcr_byte = GAP_BYTE;
          if (cnt_r == gap_len - 1'b1) begin
            cnt_nxt = '0;
            if (kind_r == CMD_HDR) begin
              state_nxt = ST_SYNC_B;
            end else begin
              oitem_nxt.run_last = 1'b1;
              state_nxt          = ST_IDLE;
            end
          end
        end
        ST_SYNC_B: begin
          oitem_nxt.gcr_byte = SYNC_BYTE;
          if (cnt_r[2:0] == SYNC_LAST) begin
            cnt_nxt            = '0;
            oitem_nxt.run_last = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= CMD_GRP;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
    shift_r <= shift_nxt;
    oitem_r <= oitem_nxt;
  end

endmodule

// File: rtl/disk_sector_gcr_encoder.sv
// top level of the disk sector gcr encoder
//
// Usage: feed the 256 data bytes of a sector in order on in_item (push/full);
// the sector number is taken with the first byte. Encoded track bytes come
// out on out_item (empty/pop), oldest first; run_last marks the last byte
// caused by one input byte. Non-first bytes closing no group produce nothing.
// Flow: a taken input's request is written into the request queue; the
// expander reads it from there when idle, loads it into its shift register
// and then emits one registered byte per cycle unless pop is held off.
// Throughput: one input per cycle while the request queue has room; the single
// expander finishes all bytes of one request before it loads the next. A
// sector header makes 20 plus the header gap bytes, a group five, the closing
// group five plus the trailing gap. Inputs stall (full) only when the request
// queue fills.
// Configuration registers (track, two ids, two gap counts) are written through
// cfg_we/cfg_index/cfg_data, by the user only while idle, which the block does
// not enforce. Reset (rst_n low, synchronous) empties the queues, returns to
// sector byte 0 and loads the register defaults. When the receiver holds off
// pop, the current byte stays put and the expander and then the queue fill up.
`timescale 1ns / 1ps
module disk_sector_gcr_encoder
  import dsgcr_pkg::*;
#(
  parameter int CMD_FIFO_DEPTH = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int LVL_W = $clog2(CMD_FIFO_DEPTH + 1);

  cfg_t             cfg_r;
  logic             in_take;
  logic             cmd_wr;
  cmd_t             cmd_wdata;
  logic             cmd_rd;
  cmd_t             cmd_rdata;
  logic             cmd_empty;
  logic [LVL_W-1:0] cmd_level;
  logic             out_take;

  assign in_take  = in_push && !in_full;
  assign out_take = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_number     <= RST_TRACK;
      cfg_r.disk_id_first    <= '0;
      cfg_r.disk_id_second   <= '0;
      cfg_r.header_gap_count <= RST_GAP;
      cfg_r.tail_gap_count   <= RST_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACK: cfg_r.track_number     <= cfg_data[5:0];
        REG_ID1:   cfg_r.disk_id_first    <= cfg_data;
        REG_ID2:   cfg_r.disk_id_second   <= cfg_data;
        REG_HGAP:  cfg_r.header_gap_count <= cfg_data[5:0];
        REG_TGAP:  cfg_r.tail_gap_count   <= cfg_data[5:0];
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  dsgcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_take  (in_take),
    .in_item  (in_item),
    .cmd_wr   (cmd_wr),
    .cmd_data (cmd_wdata)
  );

  dsgcr_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_wr),
    .wr_data (cmd_wdata),
    .rd      (cmd_rd),
    .rd_data (cmd_rdata),
    .full    (in_full),
    .empty   (cmd_empty),
    .level   (cmd_level)
  );

  dsgcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_avail (!cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_rd    (cmd_rd),
    .out_pop   (out_take),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_level_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_level <= LVL_W'(CMD_FIFO_DEPTH))
    else $error("request queue level beyond depth");

  a_no_write_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_level == LVL_W'(CMD_FIFO_DEPTH) |-> !cmd_wr)
    else $error("request written into a full queue");

  a_no_read_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_rd |-> cmd_level != '0)
    else $error("request read from an empty queue");

  a_level_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_wr && !cmd_rd) |=> cmd_level == $past(cmd_level) + 1'b1)
    else $error("queue level missed a write");
`endif

endmodule
